>>> design/hbsrc_pkg.sv
// Shared types and constants for the H-bridge soft-start ramp controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package hbsrc_pkg;

    localparam int MOTOR_COUNT = 2;
    localparam int SEL_W       = 1;
    localparam int LEVEL_W     = 7;
    localparam int DUTY_W      = 10;
    localparam int GUARD_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX         = 7'd100;
    localparam logic [GUARD_W-1:0] GUARD_TIMEOUT_RST = 16'd2000;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [DUTY_W-1:0]  duty_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MOTOR_SELECT  = 2'd0,
        REG_TARGET_SPEED  = 2'd1,
        REG_INSTANT_START = 2'd2,
        REG_GUARD_TIMEOUT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         motor_select;
        level_t             target_speed;
        logic               instant_start;
        logic [GUARD_W-1:0] guard_timeout;
    } cfg_t;

    typedef struct packed {
        logic               cw_command;
        logic               ccw_command;
        logic [GUARD_W-1:0] guard_count;
        logic               brake_request;
    } in_item_t;

    typedef struct packed {
        duty_t m0_fwd_duty;
        duty_t m0_rev_duty;
        duty_t m1_fwd_duty;
        duty_t m1_rev_duty;
        logic  moving;
        logic  acted;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/hbridge_soft_ramp_controller.sv
// H-bridge soft-start ramp controller, top level.
// Each item is held in the input register, its result in the output register.
// Throughput: one item per cycle unless the output stalls; the input register
// takes a new item while a finished result waits in the output register.
// Reset (rst_n, async, low): ramps and compares clear to zero, guard_timeout
// loads 2000, other registers clear; both pipeline stages empty.
`default_nettype none

module hbridge_soft_ramp_controller #(
    parameter int PWM_PERIOD = 1000
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [hbsrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hbsrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input items
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // [0] cw_command, [1] ccw_command, [17:2] guard_count, [18] brake_request
    input  wire logic [hbsrc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Result items
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [9:0] m0_fwd_duty, [19:10] m0_rev_duty, [29:20] m1_fwd_duty,
    // [39:30] m1_rev_duty, [40] moving, [41] acted
    output      logic [hbsrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import hbsrc_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t result;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    logic      advance;

    hbsrc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the incoming item, first field in the low bits.
    assign in_item.cw_command    = s_axis_tdata[0];
    assign in_item.ccw_command   = s_axis_tdata[1];
    assign in_item.guard_count   = s_axis_tdata[2 +: GUARD_W];
    assign in_item.brake_request = s_axis_tdata[2 + GUARD_W];

    // Move the held item into the result stage whenever that stage is free
    // or being emptied this cycle; the state update happens on the same edge.
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset, qualified by the valid flags above.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    hbsrc_ramp_core #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_ramp_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Pack the result, first field in the low bits, zero fill to whole bytes.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - 4*DUTY_W - 2)'(0),
        out_item_reg.acted,
        out_item_reg.moving,
        out_item_reg.m1_rev_duty,
        out_item_reg.m1_fwd_duty,
        out_item_reg.m0_rev_duty,
        out_item_reg.m0_fwd_duty
    };

    // A skipped tick never reports motion.
    a_skip_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.acted |-> !out_item_reg.moving)
        else $error("skipped tick reports moving");

    // Compares never exceed the PWM period.
    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            out_item_reg.m0_fwd_duty <= DUTY_W'(PWM_PERIOD) &&
            out_item_reg.m0_rev_duty <= DUTY_W'(PWM_PERIOD) &&
            out_item_reg.m1_fwd_duty <= DUTY_W'(PWM_PERIOD) &&
            out_item_reg.m1_rev_duty <= DUTY_W'(PWM_PERIOD))
        else $error("compare above PWM period");

    // A bridge never drives both sides at once.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_item_reg.m0_fwd_duty == '0 || out_item_reg.m0_rev_duty == '0) &&
            (out_item_reg.m1_fwd_duty == '0 || out_item_reg.m1_rev_duty == '0))
        else $error("both sides of a bridge driven");

    // An item that advances shows up as a valid result on the next cycle.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced item lost");

    // An empty input stage always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

`default_nettype wire

>>> design/hbsrc_cfg_regs.sv
// Configuration register file: four write-only control registers.
// Depends on hbsrc_pkg.
`default_nettype none

module hbsrc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [hbsrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hbsrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output hbsrc_pkg::cfg_t                         cfg
);
    import hbsrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MOTOR_SELECT:  cfg_next.motor_select  = cfg_wdata[1:0];
                REG_TARGET_SPEED:  cfg_next.target_speed  = cfg_wdata[LEVEL_W-1:0];
                REG_INSTANT_START: cfg_next.instant_start = cfg_wdata[0];
                REG_GUARD_TIMEOUT: cfg_next.guard_timeout = cfg_wdata[GUARD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_select  <= 2'd0;
            cfg_reg.target_speed  <= '0;
            cfg_reg.instant_start <= 1'b0;
            cfg_reg.guard_timeout <= GUARD_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/hbsrc_scale.sv
// Percent-to-compare scaling: level * PWM_PERIOD / 100 by a constant reciprocal.
// Depends on hbsrc_pkg.
`default_nettype none

module hbsrc_scale #(
    parameter int PWM_PERIOD = 1000
) (
    input  wire hbsrc_pkg::level_t level,
    output hbsrc_pkg::duty_t       duty
);
    import hbsrc_pkg::*;

    // floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x below about 199000,
    // and x = level * PWM_PERIOD stays below 128 * 1000. Folding PWM_PERIOD
    // into the constant leaves a single multiply.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = 167773;
    localparam int SCALE       = PWM_PERIOD * RECIP;
    localparam int SCALE_W     = $clog2(SCALE + 1);
    localparam int MUL_W       = LEVEL_W + SCALE_W;
    localparam int PROD_W      = (MUL_W > RECIP_SHIFT + DUTY_W) ? MUL_W
                                                                : RECIP_SHIFT + DUTY_W;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(level) * PROD_W'(SCALE);
    assign duty = prod[RECIP_SHIFT +: DUTY_W];

endmodule

`default_nettype wire

>>> design/hbsrc_ramp_core.sv
// Ramp and bridge state with the per-tick update logic.
// Depends on hbsrc_pkg and hbsrc_scale.
`default_nettype none

module hbsrc_ramp_core #(
    parameter int PWM_PERIOD = 1000
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hbsrc_pkg::cfg_t     cfg,
    input  wire logic                advance,
    input  wire hbsrc_pkg::in_item_t item,
    output hbsrc_pkg::out_item_t     result
);
    import hbsrc_pkg::*;

    level_t ramp_reg  [MOTOR_COUNT];
    level_t ramp_next [MOTOR_COUNT];
    duty_t  duty_reg  [2*MOTOR_COUNT];
    duty_t  duty_next [2*MOTOR_COUNT];

    level_t ramp_base [MOTOR_COUNT];
    duty_t  duty_base [2*MOTOR_COUNT];
    duty_t  scaled    [MOTOR_COUNT];

    logic             sel_ok;
    logic [SEL_W-1:0] sel;
    level_t           tgt;
    logic             timed_out;
    logic             go_cw;
    logic             go_ccw;
    logic             cmd;

    assign sel_ok    = ~cfg.motor_select[1];
    assign sel       = cfg.motor_select[SEL_W-1:0];
    assign tgt       = (cfg.target_speed > LEVEL_MAX) ? LEVEL_MAX : cfg.target_speed;
    assign timed_out = item.guard_count > cfg.guard_timeout;
    assign go_cw     = item.cw_command & ~timed_out;
    assign go_ccw    = item.ccw_command & ~item.cw_command & ~timed_out;
    assign cmd       = go_cw | go_ccw;

    // New ramp levels: step or jump the selected motor, or decay both.
    always_comb
    begin
        level_t lv;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            ramp_base[m] = (item.brake_request | timed_out) ? '0 : ramp_reg[m];
            duty_base[2*m]     = item.brake_request ? '0 : duty_reg[2*m];
            duty_base[2*m + 1] = item.brake_request ? '0 : duty_reg[2*m + 1];
            lv = ramp_base[m];
            if (cmd)
            begin
                if (SEL_W'(m) == sel)
                begin
                    if (cfg.instant_start)
                        lv = tgt;
                    if (lv < tgt)
                        lv = lv + 1'b1;
                end
            end
            else if (lv != '0)
            begin
                lv = lv - 1'b1;
            end
            ramp_next[m] = lv;
        end
    end

    for (genvar g = 0; g < MOTOR_COUNT; g++)
    begin : g_scale
        hbsrc_scale #(
            .PWM_PERIOD (PWM_PERIOD)
        ) u_scale (
            .level (ramp_next[g]),
            .duty  (scaled[g])
        );
    end

    // New compares: commanded side on the selected bridge, or all bridges coast.
    always_comb
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            duty_next[2*m]     = duty_base[2*m];
            duty_next[2*m + 1] = duty_base[2*m + 1];
            if (cmd)
            begin
                if (SEL_W'(m) == sel)
                begin
                    duty_next[2*m]     = go_cw ? scaled[m] : '0;
                    duty_next[2*m + 1] = go_cw ? '0 : scaled[m];
                end
            end
            else if (duty_base[2*m] == '0)
            begin
                duty_next[2*m]     = '0;
                duty_next[2*m + 1] = scaled[m];
            end
            else
            begin
                duty_next[2*m]     = scaled[m];
                duty_next[2*m + 1] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
                ramp_reg[m] <= '0;
            for (int d = 0; d < 2*MOTOR_COUNT; d++)
                duty_reg[d] <= '0;
        end
        else if (advance && sel_ok)
        begin
            ramp_reg <= ramp_next;
            duty_reg <= duty_next;
        end
    end

    always_comb
    begin
        if (sel_ok)
        begin
            result.m0_fwd_duty = duty_next[0];
            result.m0_rev_duty = duty_next[1];
            result.m1_fwd_duty = duty_next[2];
            result.m1_rev_duty = duty_next[3];
            result.moving      = cmd;
            result.acted       = 1'b1;
        end
        else
        begin
            result.m0_fwd_duty = duty_reg[0];
            result.m0_rev_duty = duty_reg[1];
            result.m1_fwd_duty = duty_reg[2];
            result.m1_rev_duty = duty_reg[3];
            result.moving      = 1'b0;
            result.acted       = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> test/tb_hbridge_soft_ramp_controller.sv
// Self-checking testbench for hbridge_soft_ramp_controller: a directed table, then random
// ticks under several stall patterns, each result checked against a typed or modelled value.
// Depends on hbsrc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_hbridge_soft_ramp_controller;
    import hbsrc_pkg::*;

    localparam int PWM_PERIOD     = 1000;
    localparam int STALL_LIMIT    = 4000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES    = 80;    // long output hold-off to back up the pipeline
    localparam int MAX_REPORTS    = 10;
    localparam int ITEMS_PER_PART = 60;

    typedef enum logic {ROW_SETTING, ROW_ITEM} row_kind_t;

    // One line of the directed table: either a full register setting or one tick.
    typedef struct {
        row_kind_t          kind;
        logic [1:0]         sel;
        level_t             tgt;
        logic               inst;
        logic [GUARD_W-1:0] tmo;
        in_item_t           tick;
        logic               typed;
        out_item_t          result;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] cw_command, [1] ccw_command, [17:2] guard_count, [18] brake_request
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [9:0] m0_fwd_duty, [19:10] m0_rev_duty, [29:20] m1_fwd_duty,
    // [39:30] m1_rev_duty, [40] moving, [41] acted
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Register mirror and bridge state, as the controller should hold them.
    logic [1:0]         sel_reg;
    level_t             target_reg;
    logic               instant_reg;
    logic [GUARD_W-1:0] timeout_reg;
    level_t             ramp_pct [MOTOR_COUNT];
    duty_t              compare_val [2*MOTOR_COUNT];

    out_item_t expected_duties [$];
    stim_row_t directed_rows [$];

    int  mismatch_count = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    bit  hold_req       = 1'b0;

    hbridge_soft_ramp_controller #(.PWM_PERIOD(PWM_PERIOD)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Percent level to compare value; keep the low ten bits as the bridge register does.
    function automatic duty_t level_to_duty(level_t lvl);
        int unsigned scaled;
        scaled = PWM_PERIOD * lvl / 100;
        return scaled[DUTY_W-1:0];
    endfunction

    // Advance both bridges by one tick and return the compares they should report.
    function automatic out_item_t advance_bridges(in_item_t tick);
        out_item_t res;
        logic      cw;
        logic      ccw;
        int        sel;
        level_t    tgt;
        duty_t     d;
        res = '0;
        cw  = tick.cw_command;
        ccw = tick.ccw_command;
        if (sel_reg <= 2'd1)
        begin
            sel = int'(sel_reg[0]);
            tgt = (target_reg > LEVEL_MAX) ? LEVEL_MAX : target_reg;
            res.acted = 1'b1;
            // Brake clears everything, then the tick goes on as usual.
            if (tick.brake_request)
            begin
                foreach (ramp_pct[m]) ramp_pct[m] = '0;
                foreach (compare_val[k]) compare_val[k] = '0;
            end
            // Lost link: drop both commands and both ramps.
            if (tick.guard_count > timeout_reg)
            begin
                cw  = 1'b0;
                ccw = 1'b0;
                foreach (ramp_pct[m]) ramp_pct[m] = '0;
            end
            if (cw || ccw)
            begin
                res.moving = 1'b1;
                if (instant_reg)
                    ramp_pct[sel] = tgt;
                if (ramp_pct[sel] < tgt)
                    ramp_pct[sel] = ramp_pct[sel] + 1'b1;
                d = level_to_duty(ramp_pct[sel]);
                compare_val[2*sel]   = cw ? d : '0;
                compare_val[2*sel+1] = cw ? '0 : d;
            end
            else
            begin
                // Coast down on whichever side the bridge was last driving.
                for (int m = 0; m < MOTOR_COUNT; m++)
                begin
                    if (ramp_pct[m] != 0)
                        ramp_pct[m] = ramp_pct[m] - 1'b1;
                    d = level_to_duty(ramp_pct[m]);
                    if (compare_val[2*m] == 0)
                        compare_val[2*m+1] = d;
                    else
                    begin
                        compare_val[2*m]   = d;
                        compare_val[2*m+1] = '0;
                    end
                end
            end
        end
        res.m0_fwd_duty = compare_val[0];
        res.m0_rev_duty = compare_val[1];
        res.m1_fwd_duty = compare_val[2];
        res.m1_rev_duty = compare_val[3];
        return res;
    endfunction

    function automatic void add_setting(logic [1:0] sel, level_t tgt, logic inst,
                                        logic [GUARD_W-1:0] tmo);
        stim_row_t row;
        row      = '{kind: ROW_SETTING, default: '0};
        row.sel  = sel;
        row.tgt  = tgt;
        row.inst = inst;
        row.tmo  = tmo;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(logic cw, logic ccw, logic [GUARD_W-1:0] guard,
                                     logic brake);
        stim_row_t row;
        row      = '{kind: ROW_ITEM, default: '0};
        row.tick = '{cw_command: cw, ccw_command: ccw, guard_count: guard,
                     brake_request: brake};
        directed_rows.push_back(row);
    endfunction

    // A tick whose outcome is plain enough to type in.
    function automatic void add_tick_typed(logic cw, logic ccw, logic [GUARD_W-1:0] guard,
                                           logic brake, duty_t m0f, duty_t m0r, duty_t m1f,
                                           duty_t m1r, logic mv, logic ac);
        add_tick(cw, ccw, guard, brake);
        directed_rows[$].typed  = 1'b1;
        directed_rows[$].result = '{m0_fwd_duty: m0f, m0_rev_duty: m0r, m1_fwd_duty: m1f,
                                    m1_rev_duty: m1r, moving: mv, acted: ac};
    endfunction

    // Offer one tick, wait for it to be taken, then queue what it should produce.
    // Returns at the accepting edge with nothing scheduled on tvalid.
    task automatic push_tick(in_item_t tick, logic typed, out_item_t typed_res);
        out_item_t predicted;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, tick.brake_request, tick.guard_count,
                          tick.ccw_command, tick.cw_command};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = advance_bridges(tick);
        expected_duties.push_back(typed ? typed_res : predicted);
    endtask

    // Drop the input and let every outstanding result drain before touching registers.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write all four registers back to back, then drop the write enable.
    task automatic apply_setting(logic [1:0] sel, level_t tgt, logic inst,
                                 logic [GUARD_W-1:0] tmo);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MOTOR_SELECT;
        cfg_wdata <= {14'b0, sel};
        @(posedge clk);
        cfg_index <= REG_TARGET_SPEED;
        cfg_wdata <= {9'b0, tgt};
        @(posedge clk);
        cfg_index <= REG_INSTANT_START;
        cfg_wdata <= {15'b0, inst};
        @(posedge clk);
        cfg_index <= REG_GUARD_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sel_reg     = sel;
        target_reg  = tgt;
        instant_reg = inst;
        timeout_reg = tmo;
    endtask

    // Result side: check each accepted item against the oldest expectation, then
    // choose tready for the next edge. A hold request parks tready low for a long
    // stretch so the pipeline fills and the input side stalls.
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.m0_fwd_duty = m_axis_tdata[9:0];
            got.m0_rev_duty = m_axis_tdata[19:10];
            got.m1_fwd_duty = m_axis_tdata[29:20];
            got.m1_rev_duty = m_axis_tdata[39:30];
            got.moving      = m_axis_tdata[40];
            got.acted       = m_axis_tdata[41];
            if (expected_duties.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result item: tdata=%h", m_axis_tdata);
            end
            else
            begin
                want = expected_duties.pop_front();
                if (got.m0_fwd_duty !== want.m0_fwd_duty ||
                    got.m0_rev_duty !== want.m0_rev_duty ||
                    got.m1_fwd_duty !== want.m1_fwd_duty ||
                    got.m1_rev_duty !== want.m1_rev_duty ||
                    got.moving !== want.moving || got.acted !== want.acted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected m0 %0d/%0d m1 %0d/%0d moving %0b acted %0b",
                                 want.m0_fwd_duty, want.m0_rev_duty, want.m1_fwd_duty,
                                 want.m1_rev_duty, want.moving, want.acted);
                        $display("          actual   m0 %0d/%0d m1 %0d/%0d moving %0b acted %0b",
                                 got.m0_fwd_duty, got.m0_rev_duty, got.m1_fwd_duty,
                                 got.m1_rev_duty, got.moving, got.acted);
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        in_item_t   tick;
        logic       cw_run;
        logic       ccw_run;
        logic [1:0] rnd_sel;
        level_t     rnd_tgt;
        logic       rnd_inst;
        logic [15:0] rnd_tmo;
        int         pick;

        // Register mirror and bridges as they come out of reset.
        sel_reg     = 2'd0;
        target_reg  = '0;
        instant_reg = 1'b0;
        timeout_reg = GUARD_TIMEOUT_RST;
        foreach (ramp_pct[m]) ramp_pct[m] = '0;
        foreach (compare_val[k]) compare_val[k] = '0;
        cw_run  = 1'b1;
        ccw_run = 1'b0;

        // Directed table. Reset setting first: zero target, ramping, timeout 2000.
        add_tick_typed(0, 0, 16'd0, 0, 0, 0, 0, 0, 0, 1);        // idle tick after reset
        add_tick_typed(1, 0, 16'd0, 0, 0, 0, 0, 0, 1, 1);        // command with zero target
        add_setting(2'd0, 7'd100, 1'b1, 16'd2000);
        add_tick_typed(1, 0, 16'd0, 0, 1000, 0, 0, 0, 1, 1);     // instant jump to full
        add_tick_typed(0, 1, 16'd0, 0, 0, 1000, 0, 0, 1, 1);     // reverse side
        add_tick_typed(1, 1, 16'd0, 0, 1000, 0, 0, 0, 1, 1);     // both: clockwise wins
        add_tick_typed(0, 0, 16'd0, 0, 990, 0, 0, 0, 0, 1);      // coast on forward side
        add_tick_typed(1, 0, 16'd2001, 0, 0, 0, 0, 0, 0, 1);     // guard just past timeout
        add_tick_typed(1, 0, 16'd2000, 0, 1000, 0, 0, 0, 1, 1);  // guard at timeout
        add_tick(1, 0, 16'd0, 1);                                // brake with command
        add_tick_typed(0, 0, 16'd0, 1, 0, 0, 0, 0, 0, 1);        // brake alone
        add_setting(2'd0, 7'd127, 1'b0, 16'd2000);               // target above 100
        add_tick(0, 1, 16'd0, 0);
        add_tick(0, 1, 16'd0, 0);
        add_tick(0, 1, 16'd0, 0);
        add_setting(2'd1, 7'd127, 1'b0, 16'd2000);
        add_tick(1, 0, 16'd0, 0);
        add_tick(0, 1, 16'hFFFF, 0);
        add_setting(2'd1, 7'd127, 1'b0, 16'd0);                  // zero timeout
        add_tick(1, 0, 16'd0, 0);
        add_tick(1, 0, 16'd1, 0);
        add_setting(2'd1, 7'd127, 1'b0, 16'hFFFF);               // timeout never trips
        add_tick(0, 1, 16'hFFFF, 0);
        add_setting(2'd2, 7'd127, 1'b1, 16'hFFFF);               // disabled selections
        add_tick(1, 0, 16'd0, 0);
        add_setting(2'd3, 7'd0, 1'b1, 16'd0);
        add_tick(1, 1, 16'hFFFF, 1);
        add_setting(2'd0, 7'd100, 1'b1, 16'd2000);
        add_tick(1, 0, 16'd0, 0);
        add_setting(2'd0, 7'd50, 1'b0, 16'd2000);                // ramp above target, held
        add_tick(1, 0, 16'd0, 0);
        add_setting(2'd0, 7'd50, 1'b1, 16'd2000);                // instant pulls down to target
        add_tick(0, 1, 16'd0, 0);
        add_tick(0, 0, 16'd0, 0);                                // coast on reverse side

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_SETTING)
            begin
                settle_idle();
                apply_setting(directed_rows[i].sel, directed_rows[i].tgt,
                              directed_rows[i].inst, directed_rows[i].tmo);
            end
            else
                push_tick(directed_rows[i].tick, directed_rows[i].typed,
                          directed_rows[i].result);
        end

        // Random part: six phases of stall patterns, two register settings each.
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int part = 0; part < 2; part++)
            begin
                settle_idle();
                case (phase)
                    1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                    3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
                    default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                endcase
                // Mostly live selections; now and then a disabled one.
                pick    = $urandom_range(0, 9);
                rnd_sel = (pick < 5) ? 2'd0 : (pick < 9) ? 2'd1 : 2'($urandom_range(2, 3));
                case ($urandom_range(0, 4))
                    0:       rnd_tgt = 7'd0;
                    1:       rnd_tgt = 7'd100;
                    2:       rnd_tgt = 7'd127;
                    3:       rnd_tgt = 7'($urandom_range(0, 127));
                    default: rnd_tgt = 7'($urandom_range(1, 100));
                endcase
                rnd_inst = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 3))
                    0:       rnd_tmo = 16'd0;
                    1:       rnd_tmo = 16'hFFFF;
                    2:       rnd_tmo = GUARD_TIMEOUT_RST;
                    default: rnd_tmo = 16'($urandom_range(0, 65535));
                endcase
                apply_setting(rnd_sel, rnd_tgt, rnd_inst, rnd_tmo);

                for (int n = 0; n < ITEMS_PER_PART; n++)
                begin
                    // Park the result side early in the pressure phase.
                    if (phase == 4 && part == 0 && n == 10)
                        hold_req = 1'b1;
                    // Hold a direction for a run of ticks so ramps climb deep.
                    if ($urandom_range(0, 23) == 0)
                    begin
                        pick    = $urandom_range(0, 7);
                        cw_run  = (pick == 1) || (pick >= 2 && pick <= 4);
                        ccw_run = (pick == 1) || (pick >= 5);
                    end
                    tick.cw_command  = cw_run;
                    tick.ccw_command = ccw_run;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        tick.cw_command  = 1'($urandom_range(0, 1));
                        tick.ccw_command = 1'($urandom_range(0, 1));
                    end
                    tick.brake_request = ($urandom_range(0, 39) == 0);
                    if ($urandom_range(0, 99) < 85)
                        tick.guard_count = 16'($urandom_range(0, timeout_reg));
                    else
                        tick.guard_count = 16'($urandom_range(0, 65535));
                    push_tick(tick, 1'b0, '0);
                end
            end
        end

        // Drain; the watchdog covers a result that never arrives.
        s_axis_tvalid <= 1'b0;
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
design/hbsrc_pkg.sv
design/hbsrc_cfg_regs.sv
design/hbsrc_scale.sv
design/hbsrc_ramp_core.sv
design/hbridge_soft_ramp_controller.sv
test/tb_hbridge_soft_ramp_controller.sv
